// File: hw/rtl/tscd_pkg.sv
// package for the tab-separated command deframer: types, codes and character constants
package tscd_pkg;

  // stream characters
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // sizes
  localparam int unsigned MAX_FIELD_BYTES = 256;
  localparam int unsigned FLEN_W          = $clog2(MAX_FIELD_BYTES + 1);
  localparam int unsigned LEN_W           = 14;
  localparam logic [LEN_W-1:0] COUNTER_MAX = {LEN_W{1'b1}};
  localparam int unsigned CFG_DATA_W      = 4;
  localparam int unsigned CFG_IDX_W       = 1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_FIELDS   = 1'b0,
    CFG_CHECK_LENGTH = 1'b1
  } cfg_idx_t;

  // deframer phase
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HUNT   = 3'd1,
    PH_SKIP   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_BODY   = 3'd4,
    PH_END    = 3'd5
  } phase_t;

  // result kinds
  typedef enum logic [2:0] {
    KIND_FRAME       = 3'd0,
    KIND_DATA        = 3'd1,
    KIND_FIELD_CLOSE = 3'd2,
    KIND_MSG_DONE    = 3'd3,
    KIND_ERROR       = 3'd4
  } kind_t;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_NO_START   = 3'd1,
    ERR_BAD_DIGIT  = 3'd2,
    ERR_TOO_MANY   = 3'd3,
    ERR_FIELD_LONG = 3'd4,
    ERR_LENGTH     = 3'd5
  } err_t;

endpackage

// File: hw/rtl/tab_separated_command_deframer.sv
// tab-separated command deframer: input register, one-pass byte classifier, result register
// an accepted input beat goes through the input register, then the result register, to its result beat
// throughput: one byte per cycle while the output is not stalled; the per-byte phase/counter update is one short step
// a full result register that is stalled holds the input register, which then stalls input
// reset (rst_n low, synchronous): phase idle, counters zero, max_fields 3, check_length 1
// both pipeline registers empty after reset
module tab_separated_command_deframer (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_byte,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         out_kind,
  output logic [7:0]                         out_data_byte,
  output logic [3:0]                         out_field_index,
  output logic [tscd_pkg::FLEN_W-1:0]        out_field_length,
  output logic [tscd_pkg::LEN_W-1:0]         out_declared_length,
  output logic [3:0]                         out_field_count,
  output logic                               out_length_ok,
  output logic [2:0]                         out_error_code,
  // configuration port
  input  logic                               cfg_we,
  input  logic [tscd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tscd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned FW = tscd_pkg::FLEN_W;
  localparam int unsigned LW = tscd_pkg::LEN_W;

  // configuration registers
  logic [3:0] max_fields_r;
  logic       check_length_r;

  // pipeline registers
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  logic       advance;

  // deframer state
  tscd_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]       digit_pos_r, digit_pos_nxt;
  logic [LW-1:0]    len_acc_r, len_acc_nxt;
  logic [LW-1:0]    byte_cnt_r, byte_cnt_nxt;
  logic [3:0]       fields_r, fields_nxt;
  logic [FW-1:0]    cur_bytes_r, cur_bytes_nxt;

  // result fields
  tscd_pkg::kind_t  kind_nxt, kind_r;
  tscd_pkg::err_t   err_nxt, err_r;
  logic [7:0]       data_nxt, data_r;
  logic [3:0]       idx_nxt, idx_r;
  logic [FW-1:0]    flen_nxt, flen_r;
  logic [LW-1:0]    dlen_nxt, dlen_r;
  logic [3:0]       cnt_nxt, cnt_r;
  logic             ok_nxt, ok_r;

  // handshake
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_fields_r   <= 4'd3;
      check_length_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (tscd_pkg::cfg_idx_t'(cfg_index))
        tscd_pkg::CFG_MAX_FIELDS:   max_fields_r   <= cfg_data[3:0];
        tscd_pkg::CFG_CHECK_LENGTH: check_length_r <= cfg_data[0];
        default:                    max_fields_r   <= max_fields_r;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_byte;
    end
  end

  // byte classifier and next state
  always_comb begin
    logic [LW-1:0] cnt_inc;
    logic [3:0]    digit;
    logic          closing;
    logic          len_match;
    phase_nxt     = phase_r;
    digit_pos_nxt = digit_pos_r;
    len_acc_nxt   = len_acc_r;
    byte_cnt_nxt  = byte_cnt_r;
    fields_nxt    = fields_r;
    cur_bytes_nxt = cur_bytes_r;
    kind_nxt      = tscd_pkg::KIND_FRAME;
    err_nxt       = tscd_pkg::ERR_NONE;
    data_nxt      = '0;
    idx_nxt       = '0;
    flen_nxt      = '0;
    dlen_nxt      = '0;
    cnt_nxt       = '0;
    ok_nxt        = 1'b0;
    cnt_inc       = (byte_cnt_r != tscd_pkg::COUNTER_MAX) ? byte_cnt_r + LW'(1) : byte_cnt_r;
    digit         = in_byte_r[3:0] - tscd_pkg::CH_ZERO[3:0];
    closing       = (cur_bytes_r != '0);
    len_match     = (cnt_inc == len_acc_r);

    unique case (phase_r)
      tscd_pkg::PH_IDLE, tscd_pkg::PH_HUNT, tscd_pkg::PH_END: begin
        if (in_byte_r == tscd_pkg::CH_STAR) begin
          phase_nxt     = tscd_pkg::PH_SKIP;
          digit_pos_nxt = '0;
          len_acc_nxt   = '0;
          byte_cnt_nxt  = LW'(1);
          fields_nxt    = '0;
          cur_bytes_nxt = '0;
        end else if (phase_r == tscd_pkg::PH_HUNT) begin
          phase_nxt = tscd_pkg::PH_HUNT;
        end else if (phase_r == tscd_pkg::PH_END && in_byte_r == tscd_pkg::CH_LF) begin
          phase_nxt = tscd_pkg::PH_IDLE;
        end else begin
          kind_nxt  = tscd_pkg::KIND_ERROR;
          err_nxt   = tscd_pkg::ERR_NO_START;
          dlen_nxt  = len_acc_r;
          phase_nxt = tscd_pkg::PH_HUNT;
        end
      end
      // byte after the start mark is ignored
      tscd_pkg::PH_SKIP: begin
        byte_cnt_nxt  = cnt_inc;
        phase_nxt     = tscd_pkg::PH_DIGITS;
        digit_pos_nxt = '0;
      end
      // four length digits, most significant first
      tscd_pkg::PH_DIGITS: begin
        byte_cnt_nxt = cnt_inc;
        if (in_byte_r < tscd_pkg::CH_ZERO || in_byte_r > tscd_pkg::CH_NINE) begin
          kind_nxt      = tscd_pkg::KIND_ERROR;
          err_nxt       = tscd_pkg::ERR_BAD_DIGIT;
          dlen_nxt      = len_acc_r;
          phase_nxt     = tscd_pkg::PH_HUNT;
          digit_pos_nxt = '0;
        end else begin
          // acc * 10 + digit as two shifted adds
          len_acc_nxt = {len_acc_r[LW-4:0], 3'b000} + {len_acc_r[LW-2:0], 1'b0}
                      + LW'(digit);
          if (digit_pos_r == 2'd3) begin
            digit_pos_nxt = '0;
            phase_nxt     = tscd_pkg::PH_BODY;
          end else begin
            digit_pos_nxt = digit_pos_r + 2'd1;
          end
        end
      end
      // fields, tab separators and end mark
      tscd_pkg::PH_BODY: begin
        byte_cnt_nxt = cnt_inc;
        if (in_byte_r == tscd_pkg::CH_TAB || in_byte_r == tscd_pkg::CH_BANG) begin
          if (closing && fields_r >= max_fields_r) begin
            kind_nxt  = tscd_pkg::KIND_ERROR;
            err_nxt   = tscd_pkg::ERR_TOO_MANY;
            dlen_nxt  = len_acc_r;
            phase_nxt = tscd_pkg::PH_HUNT;
          end else begin
            if (closing) begin
              idx_nxt       = fields_r;
              flen_nxt      = cur_bytes_r;
              fields_nxt    = fields_r + 4'd1;
              cur_bytes_nxt = '0;
            end
            if (in_byte_r == tscd_pkg::CH_TAB) begin
              if (closing) begin
                kind_nxt = tscd_pkg::KIND_FIELD_CLOSE;
              end
            end else if (check_length_r && !len_match) begin
              kind_nxt  = tscd_pkg::KIND_ERROR;
              err_nxt   = tscd_pkg::ERR_LENGTH;
              idx_nxt   = '0;
              flen_nxt  = '0;
              dlen_nxt  = len_acc_r;
              phase_nxt = tscd_pkg::PH_HUNT;
            end else begin
              kind_nxt  = tscd_pkg::KIND_MSG_DONE;
              dlen_nxt  = len_acc_r;
              cnt_nxt   = closing ? fields_r + 4'd1 : fields_r;
              ok_nxt    = len_match;
              phase_nxt = tscd_pkg::PH_END;
            end
          end
        end else if (cur_bytes_r >= FW'(tscd_pkg::MAX_FIELD_BYTES)) begin
          kind_nxt  = tscd_pkg::KIND_ERROR;
          err_nxt   = tscd_pkg::ERR_FIELD_LONG;
          dlen_nxt  = len_acc_r;
          phase_nxt = tscd_pkg::PH_HUNT;
        end else begin
          cur_bytes_nxt = cur_bytes_r + FW'(1);
          kind_nxt      = tscd_pkg::KIND_DATA;
          data_nxt      = in_byte_r;
          idx_nxt       = fields_r;
        end
      end
      default: begin
        phase_nxt = tscd_pkg::PH_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tscd_pkg::PH_IDLE;
      digit_pos_r <= '0;
      len_acc_r   <= '0;
      byte_cnt_r  <= '0;
      fields_r    <= '0;
      cur_bytes_r <= '0;
    end else if (advance) begin
      phase_r     <= phase_nxt;
      digit_pos_r <= digit_pos_nxt;
      len_acc_r   <= len_acc_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      fields_r    <= fields_nxt;
      cur_bytes_r <= cur_bytes_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      kind_r <= kind_nxt;
      err_r  <= err_nxt;
      data_r <= data_nxt;
      idx_r  <= idx_nxt;
      flen_r <= flen_nxt;
      dlen_r <= dlen_nxt;
      cnt_r  <= cnt_nxt;
      ok_r   <= ok_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = kind_r;
  assign out_data_byte       = data_r;
  assign out_field_index     = idx_r;
  assign out_field_length    = flen_r;
  assign out_declared_length = dlen_r;
  assign out_field_count     = cnt_r;
  assign out_length_ok       = ok_r;
  assign out_error_code      = err_r;

  // a completed message never holds more fields than allowed
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == tscd_pkg::KIND_MSG_DONE |-> cnt_r <= max_fields_r)
    else $error("message field count above max_fields");

  // an error beat carries a code and other beats carry none
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((kind_r == tscd_pkg::KIND_ERROR) == (err_r != tscd_pkg::ERR_NONE)))
    else $error("error code does not match result kind");

  // field byte count stays within the field limit
  a_field_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    cur_bytes_r <= FW'(tscd_pkg::MAX_FIELD_BYTES))
    else $error("field byte count past limit");

  // a stalled input beat waits in the input register
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_valid_r && $stable(in_byte_r))
    else $error("input register lost a stalled beat");

endmodule
